>>> src/flpw_pkg.sv
package flpw_pkg;

    localparam logic [1:0] CMD_FILT_DEF = 2'd0;
    localparam logic [1:0] CMD_FILT_PER = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;
    localparam logic [1:0] CMD_NOP      = 2'd3;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_OMEGA = 2'd1;
    localparam logic [1:0] REG_WRAP  = 2'd2;

    localparam logic [15:0] ALPHA_RESET = 16'd6554;

    localparam int DIV_W     = 41;
    localparam int DVD_W     = 33;
    localparam int STEP_W    = 6;

    localparam logic [DIV_W-1:0]  ONE_Q24     = 41'd16777216;
    localparam logic [STEP_W-1:0] ALPHA_STEPS = 6'd16;
    localparam logic [STEP_W-1:0] WRAP_STEPS  = 6'd33;

    typedef struct packed {
        logic capture;
        logic clear_state;
        logic pass_first;
        logic load_alpha_def;
        logic mul_w;
        logic div_alpha;
        logic take_alpha;
        logic load_diff;
        logic mul_step;
        logic load_sum;
        logic wrap_add;
        logic div_mod;
        logic take_wrap;
        logic load_out;
    } flpw_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       first;
        logic       wrap_en;
        logic       div_done;
        logic       out_free;
    } flpw_stat_t;

endpackage

>>> src/flpw_div.sv
module flpw_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [flpw_pkg::DIV_W-1:0]  rem_init,
    input  logic [flpw_pkg::DVD_W-1:0]  dividend,
    input  logic [flpw_pkg::DIV_W-1:0]  divisor,
    input  logic [flpw_pkg::STEP_W-1:0] steps,
    output logic                        done,
    output logic [15:0]                 quot,
    output logic [flpw_pkg::DIV_W-1:0]  rem
);
    import flpw_pkg::*;

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [15:0]       quot_reg;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    trial_sub;
    logic              fits;

    // shift one dividend bit into the partial remainder
    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign fits      = (trial >= {1'b0, div_reg});
    assign rem_next  = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = steps;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= rem_init;
            dvd_reg  <= dividend;
            div_reg  <= divisor;
            quot_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg  <= rem_next;
            dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
            quot_reg <= {quot_reg[14:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

>>> src/flpw_datapath.sv
module flpw_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  flpw_pkg::flpw_cmd_t    ctl,
    output flpw_pkg::flpw_stat_t   stat,
    input  logic [1:0]             s_cmd,
    input  logic signed [31:0]     s_sample,
    input  logic [15:0]            s_period,
    input  logic                   cfg_wr,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [31:0]     m_filtered
);
    import flpw_pkg::*;

    logic [15:0]        alpha_def_reg;
    logic [23:0]        omega_reg;
    logic [30:0]        wrap_half_reg;

    logic [1:0]         cmd_reg;
    logic signed [31:0] x_reg;
    logic [15:0]        period_reg;
    logic [39:0]        w_reg;
    logic [15:0]        alpha_reg;
    logic signed [31:0] last_reg;
    logic               first_reg;
    logic signed [32:0] v_reg;
    logic signed [49:0] prod_reg;
    logic signed [33:0] n_reg;
    logic signed [31:0] out_reg;
    logic               m_valid_reg;

    logic [39:0]        w_prod;
    logic signed [32:0] diff;
    logic signed [49:0] prod_full;
    logic signed [33:0] sum;
    logic signed [33:0] n_sum;
    logic [33:0]        n_mag;
    logic [31:0]        wrap_rem;
    logic [33:0]        wrap_lo;
    logic [33:0]        wrap_hi;
    logic [32:0]        wrap_res;
    logic signed [31:0] sat_val;

    logic               div_start;
    logic [DIV_W-1:0]   div_rem_init;
    logic [DVD_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic [STEP_W-1:0]  div_steps;
    logic               div_done;
    logic [15:0]        div_quot;
    logic [DIV_W-1:0]   div_rem;

    assign w_prod    = omega_reg * period_reg;
    assign diff      = {x_reg[31], x_reg} - {last_reg[31], last_reg};
    assign prod_full = $signed({1'b0, alpha_reg}) * v_reg;
    // arithmetic shift floors the scaled step
    assign sum       = {{2{last_reg[31]}}, last_reg} + prod_reg[49:16];
    assign n_sum     = {v_reg[32], v_reg} + $signed({3'b000, wrap_half_reg});
    assign n_mag     = n_reg[33] ? (-n_reg) : n_reg;

    // floor modulo: a negative numerator with a nonzero remainder folds back
    assign wrap_rem  = div_rem[31:0];
    assign wrap_lo   = {2'b00, wrap_rem} - {3'b000, wrap_half_reg};
    assign wrap_hi   = {3'b000, wrap_half_reg} - {2'b00, wrap_rem};
    assign wrap_res  = (n_reg[33] && (wrap_rem != '0)) ? wrap_hi[32:0] : wrap_lo[32:0];

    always_comb begin
        if (v_reg[32] != v_reg[31]) begin
            sat_val = v_reg[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat_val = v_reg[31:0];
        end
    end

    assign div_start    = ctl.div_alpha | ctl.div_mod;
    assign div_rem_init = ctl.div_alpha ? {1'b0, w_reg} : '0;
    assign div_dividend = ctl.div_alpha ? '0 : n_mag[32:0];
    assign div_divisor  = ctl.div_alpha ? ({1'b0, w_reg} + ONE_Q24)
                                        : {9'd0, wrap_half_reg, 1'b0};
    assign div_steps    = ctl.div_alpha ? ALPHA_STEPS : WRAP_STEPS;

    flpw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_def_reg <= ALPHA_RESET;
            omega_reg     <= '0;
            wrap_half_reg <= '0;
            last_reg      <= '0;
            first_reg     <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    REG_ALPHA: alpha_def_reg <= cfg_data[15:0];
                    REG_OMEGA: omega_reg     <= cfg_data[23:0];
                    REG_WRAP:  wrap_half_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (ctl.clear_state) begin
                last_reg  <= '0;
                first_reg <= 1'b1;
            end else if (ctl.pass_first) begin
                first_reg <= 1'b0;
            end
            if (ctl.load_out) begin
                last_reg    <= sat_val;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg    <= s_cmd;
            x_reg      <= s_sample;
            period_reg <= s_period;
        end
        if (ctl.mul_w) begin
            w_reg <= w_prod;
        end
        if (ctl.load_alpha_def) begin
            alpha_reg <= alpha_def_reg;
        end else if (ctl.take_alpha) begin
            alpha_reg <= div_quot;
        end
        if (ctl.pass_first) begin
            v_reg <= {x_reg[31], x_reg};
        end else if (ctl.load_diff) begin
            v_reg <= diff;
        end else if (ctl.load_sum) begin
            v_reg <= sum[32:0];
        end else if (ctl.take_wrap) begin
            v_reg <= wrap_res;
        end
        if (ctl.mul_step) begin
            prod_reg <= prod_full;
        end
        if (ctl.wrap_add) begin
            n_reg <= n_sum;
        end
        if (ctl.load_out) begin
            out_reg <= sat_val;
        end
    end

    assign stat.cmd      = cmd_reg;
    assign stat.first    = first_reg;
    assign stat.wrap_en  = (wrap_half_reg != '0);
    assign stat.div_done = div_done;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_filtered = out_reg;

endmodule

>>> src/flpw_ctrl.sv
module flpw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  flpw_pkg::flpw_stat_t stat,
    output flpw_pkg::flpw_cmd_t  ctl
);
    import flpw_pkg::*;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_DEC        = 4'd1;
    localparam logic [3:0] ST_ALPHA_ST   = 4'd2;
    localparam logic [3:0] ST_ALPHA_WAIT = 4'd3;
    localparam logic [3:0] ST_DIFF       = 4'd4;
    localparam logic [3:0] ST_MUL        = 4'd5;
    localparam logic [3:0] ST_ADD        = 4'd6;
    localparam logic [3:0] ST_WADD       = 4'd7;
    localparam logic [3:0] ST_WDIV_ST    = 4'd8;
    localparam logic [3:0] ST_WDIV_WAIT  = 4'd9;
    localparam logic [3:0] ST_OUT        = 4'd10;

    logic [3:0] state_reg, state_next;
    // low: wrapping the difference, high: wrapping the new output
    logic       phase_reg, phase_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        ctl        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.capture = 1'b1;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC: begin
                case (stat.cmd)
                    CMD_CLEAR: begin
                        ctl.clear_state = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    CMD_FILT_DEF, CMD_FILT_PER: begin
                        if (stat.first) begin
                            ctl.pass_first = 1'b1;
                            state_next     = ST_OUT;
                        end else if (stat.cmd == CMD_FILT_PER) begin
                            ctl.mul_w  = 1'b1;
                            state_next = ST_ALPHA_ST;
                        end else begin
                            ctl.load_alpha_def = 1'b1;
                            state_next         = ST_DIFF;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ALPHA_ST: begin
                ctl.div_alpha = 1'b1;
                state_next    = ST_ALPHA_WAIT;
            end
            ST_ALPHA_WAIT: begin
                if (stat.div_done) begin
                    ctl.take_alpha = 1'b1;
                    state_next     = ST_DIFF;
                end
            end
            ST_DIFF: begin
                ctl.load_diff = 1'b1;
                phase_next    = 1'b0;
                state_next    = stat.wrap_en ? ST_WADD : ST_MUL;
            end
            ST_MUL: begin
                ctl.mul_step = 1'b1;
                state_next   = ST_ADD;
            end
            ST_ADD: begin
                ctl.load_sum = 1'b1;
                phase_next   = 1'b1;
                state_next   = stat.wrap_en ? ST_WADD : ST_OUT;
            end
            ST_WADD: begin
                ctl.wrap_add = 1'b1;
                state_next   = ST_WDIV_ST;
            end
            ST_WDIV_ST: begin
                ctl.div_mod = 1'b1;
                state_next  = ST_WDIV_WAIT;
            end
            ST_WDIV_WAIT: begin
                if (stat.div_done) begin
                    ctl.take_wrap = 1'b1;
                    state_next    = phase_reg ? ST_OUT : ST_MUL;
                end
            end
            ST_OUT: begin
                // hold until the output register has room
                if (stat.out_free) begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

>>> src/first_order_lowpass_wrapping_top.sv
// The first sample after reset or a clear passes straight to the output; a plain filter
// step forms the difference, the scaled step and the sum, deriving alpha from the period
// adds a pass of the 16-step shared divider, and periodic mode adds two 33-step passes.
// One item is in flight at a time; the next is accepted the cycle after the result
// is loaded, or after the command is decoded for clear and unused commands.
// Synchronous active-low reset restores register defaults and the first-sample state.
module first_order_lowpass_wrapping_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_sample,
    input  logic [15:0]        s_period,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_filtered,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import flpw_pkg::*;

    flpw_cmd_t  ctl;
    flpw_stat_t stat;

    assign cfg_ready = 1'b1;

    flpw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    flpw_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .stat       (stat),
        .s_cmd      (s_cmd),
        .s_sample   (s_sample),
        .s_period   (s_period),
        .cfg_wr     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered)
    );

`ifndef SYNTHESIS
    ast_load_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_out |-> stat.out_free)
        else $error("result loaded while output register occupied");

    ast_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while one is in work");

    ast_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctl.capture, ctl.div_alpha, ctl.div_mod, ctl.load_out}))
        else $error("conflicting datapath commands");
`endif

endmodule
